// ===== hdl/pip_pkg.sv =====
// Shared types, constants and helpers for the point-in-convex-polygon block.
`timescale 1ns / 1ps
`default_nettype none

package pip_pkg;

  // Vertex store size and derived widths
  localparam int MAX_VERTICES = 1024;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

  // Field widths
  localparam int COORD_W  = 31;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int PROD_W   = 2 * DIFF_W;
  localparam int ACTION_W = 2;

  // Command queue between front end and engine
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Action codes as carried on the input tuser
  typedef enum logic [ACTION_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  typedef logic signed [COORD_W-1:0] coord_t;

  // Decoded command handed to the engine
  typedef struct packed {
    op_e    op;
    coord_t x;
    coord_t y;
  } cmd_t;

  // Engine status seen by the top level
  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic             dropped;
    logic             res_load;
    logic             res_inside;
  } stat_t;

  // Sign-extend a coordinate by one bit for exact differences
  function automatic logic signed [DIFF_W-1:0] sext(input coord_t v);
    return $signed({v[COORD_W-1], v});
  endfunction

endpackage

`default_nettype wire

// ===== hdl/point_in_convex_polygon.sv =====
// Top level of the point-in-convex-polygon block.
`timescale 1ns / 1ps
`default_nettype none

// Stores up to 1024 vertices of a convex polygon (counterclockwise) and answers
// point queries with an exact integer cross/dot product test per edge; points on
// the boundary count as inside, an empty polygon answers inside, and appends past
// capacity are dropped and reported on every later result until a clear. The input
// side decodes each transfer into a four-deep command queue; the back end takes one
// command at a time, and clear and append are done as it takes them. A query walks
// the edges: it reads one vertex per cycle from the vertex memory, followed by a
// three-stage difference/multiply/test pipeline, and stops sooner at an earlier
// deciding edge. The input keeps accepting until the queue fills, and a finished
// result waits in the output register.
module point_in_convex_polygon (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,  // x_coord[30:0], y_coord[61:31], zero pad
  input  wire logic [1:0]  s_axis_tuser,  // action[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata   // inside_res[0], overflowed[1], zero pad
);

  logic                          front_vld;
  pip_pkg::cmd_t                 front_cmd;
  logic                          fifo_rdy;
  logic                          fifo_vld;
  pip_pkg::cmd_t                 fifo_head;
  logic [pip_pkg::FIFO_AW:0]     fifo_level;
  logic                          eng_pop;
  pip_pkg::stat_t                stat;

  pip_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .fifo_rdy_i    (fifo_rdy),
    .cmd_vld_o     (front_vld),
    .cmd_o         (front_cmd)
  );

  pip_cmd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (front_vld),
    .push_cmd_i (front_cmd),
    .rdy_o      (fifo_rdy),
    .pop_i      (eng_pop),
    .vld_o      (fifo_vld),
    .head_o     (fifo_head),
    .level_o    (fifo_level)
  );

  pip_engine u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_vld_i     (fifo_vld),
    .cmd_i         (fifo_head),
    .pop_o         (eng_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .stat_o        (stat)
  );

  // Queue never holds more than its depth
  a_fifo_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_level <= (pip_pkg::FIFO_AW + 1)'(pip_pkg::FIFO_DEPTH))
    else $error("command queue over depth");

  // Drops only happen with a full store, and only a clear undoes either
  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.dropped |-> stat.cnt == (pip_pkg::CNT_W)'(pip_pkg::MAX_VERTICES))
    else $error("dropped flag set with store not full");

  // An outside answer needs at least two vertices
  a_outside_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat.res_load && !stat.res_inside) |-> stat.cnt >= (pip_pkg::CNT_W)'(2))
    else $error("outside answer with fewer than two vertices");

  // A loaded result shows on the output in the next cycle
  a_res_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.res_load |=> m_axis_tvalid)
    else $error("result lost on its way to the output");

endmodule

`default_nettype wire

// ===== hdl/pip_front.sv =====
// Input front end: takes stream transfers, decodes the action and drops unused codes.
`timescale 1ns / 1ps
`default_nettype none

module pip_front (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [63:0]                    s_axis_tdata,
  input  wire logic [pip_pkg::ACTION_W-1:0]   s_axis_tuser,
  input  wire logic                           fifo_rdy_i,
  output logic                                cmd_vld_o,
  output pip_pkg::cmd_t                       cmd_o
);

  logic          vld_q, vld_d;
  pip_pkg::cmd_t cmd_q, cmd_d;
  logic          accept;
  logic          keep;

  assign s_axis_tready = !vld_q || fifo_rdy_i;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Classify the action; the spare code is swallowed here
  always_comb begin
    keep     = 1'b0;
    cmd_d.op = pip_pkg::OP_CLEAR;
    case (s_axis_tuser)
      pip_pkg::OP_CLEAR:  begin keep = 1'b1; cmd_d.op = pip_pkg::OP_CLEAR;  end
      pip_pkg::OP_APPEND: begin keep = 1'b1; cmd_d.op = pip_pkg::OP_APPEND; end
      pip_pkg::OP_QUERY:  begin keep = 1'b1; cmd_d.op = pip_pkg::OP_QUERY;  end
      default:            keep = 1'b0;
    endcase
    cmd_d.x = s_axis_tdata[pip_pkg::COORD_W-1:0];
    cmd_d.y = s_axis_tdata[2*pip_pkg::COORD_W-1:pip_pkg::COORD_W];
  end

  // Holding register valid
  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = keep;
    end else if (fifo_rdy_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_d;
    end
  end

  assign cmd_vld_o = vld_q;
  assign cmd_o     = cmd_q;

endmodule

`default_nettype wire

// ===== hdl/pip_cmd_fifo.sv =====
// Short command queue between the front end and the engine.
`timescale 1ns / 1ps
`default_nettype none

module pip_cmd_fifo (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push_i,
  input  wire pip_pkg::cmd_t              push_cmd_i,
  output logic                            rdy_o,
  input  wire logic                       pop_i,
  output logic                            vld_o,
  output pip_pkg::cmd_t                   head_o,
  output logic [pip_pkg::FIFO_AW:0]       level_o
);

  pip_pkg::cmd_t                   slot_q [pip_pkg::FIFO_DEPTH];
  logic [pip_pkg::FIFO_AW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [pip_pkg::FIFO_AW:0]       level_q;
  logic                            do_push, do_pop;

  assign rdy_o   = level_q != (pip_pkg::FIFO_AW + 1)'(pip_pkg::FIFO_DEPTH);
  assign vld_o   = level_q != '0;
  assign do_push = push_i && rdy_o;
  assign do_pop  = pop_i && vld_o;
  assign head_o  = slot_q[rd_ptr_q];
  assign level_o = level_q;

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        level_q <= level_q + 1'b1;
      end else if (do_pop && !do_push) begin
        level_q <= level_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/pip_engine.sv =====
// Back end: vertex store, edge walk pipeline and result register.
`timescale 1ns / 1ps
`default_nettype none

module pip_engine (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cmd_vld_i,
  input  wire pip_pkg::cmd_t  cmd_i,
  output logic                pop_o,
  output logic                m_axis_tvalid,
  input  wire logic           m_axis_tready,
  output logic [7:0]          m_axis_tdata,
  output pip_pkg::stat_t      stat_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_e;

  localparam int CW = pip_pkg::CNT_W;
  localparam int AW = pip_pkg::ADDR_W;
  localparam int DW = pip_pkg::DIFF_W;
  localparam int PW = pip_pkg::PROD_W;
  localparam int VW = 2 * pip_pkg::COORD_W;

  state_e           state_q;
  logic [CW-1:0]    cnt_q;
  logic             dropped_q;
  logic             res_q;
  logic             out_vld_q, out_inside_q, out_over_q;

  // Walk control
  logic             iss_on_q;
  logic [CW-1:0]    iss_idx_q;
  logic             f_vld_q, f_first_q, f_last_q;
  logic             d_vld_q, d_last_q;
  logic             m_vld_q, m_last_q;

  // Walk payload
  pip_pkg::coord_t  px_q, py_q;
  pip_pkg::coord_t  prev_x_q, prev_y_q;
  logic [VW-1:0]    rd_q;
  logic signed [DW-1:0] d_ux_q, d_uy_q, d_vx_q, d_vy_q;
  logic signed [DW-1:0] d_ex_q, d_ey_q, d_wx_q, d_wy_q;
  logic signed [PW-1:0] m_p0_q, m_p1_q, m_p2_q, m_p3_q, m_p4_q, m_p5_q;

  logic [VW-1:0]    vmem [pip_pkg::MAX_VERTICES];

  logic             not_full;
  logic             wr_en;
  logic [AW-1:0]    rd_addr;
  pip_pkg::coord_t  rd_x, rd_y;
  logic signed [PW-1:0] cross_on, dot_on, cross_side;
  logic             on_edge, right_side, decide, decide_inside;
  logic             out_free;
  logic             walk_go, walk_stop;

  assign not_full = cnt_q < CW'(pip_pkg::MAX_VERTICES);
  assign pop_o    = (state_q == ST_IDLE) && cmd_vld_i;
  assign wr_en    = pop_o && (cmd_i.op == pip_pkg::OP_APPEND) && not_full;
  assign out_free = !out_vld_q || m_axis_tready;

  // Walk start on a query with stored vertices; stop on the first deciding edge
  assign walk_go   = pop_o && (cmd_i.op == pip_pkg::OP_QUERY) && (cnt_q != '0);
  assign walk_stop = (state_q == ST_WALK) && decide;

  // Read vertices 0..n-1, then vertex 0 again to close the polygon
  assign rd_addr = (iss_idx_q == cnt_q) ? '0 : iss_idx_q[AW-1:0];
  assign rd_x    = rd_q[pip_pkg::COORD_W-1:0];
  assign rd_y    = rd_q[VW-1:pip_pkg::COORD_W];

  // Edge tests on the registered products
  assign cross_on      = m_p0_q - m_p1_q;
  assign dot_on        = m_p2_q + m_p3_q;
  assign cross_side    = m_p4_q - m_p5_q;
  assign on_edge       = (cross_on == '0) && (dot_on <= 0);
  assign right_side    = cross_side < 0;
  assign decide        = m_vld_q && (on_edge || right_side || m_last_q);
  assign decide_inside = on_edge || !right_side;

  // Vertex memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      vmem[cnt_q[AW-1:0]] <= {cmd_i.y, cmd_i.x};
    end
    rd_q <= vmem[rd_addr];
  end

  // Sequencer, walk control and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_q        <= '0;
      dropped_q    <= 1'b0;
      res_q        <= 1'b0;
      out_vld_q    <= 1'b0;
      out_inside_q <= 1'b0;
      out_over_q   <= 1'b0;
      iss_on_q     <= 1'b0;
      iss_idx_q    <= '0;
      f_vld_q      <= 1'b0;
      f_first_q    <= 1'b0;
      f_last_q     <= 1'b0;
      d_vld_q      <= 1'b0;
      d_last_q     <= 1'b0;
      m_vld_q      <= 1'b0;
      m_last_q     <= 1'b0;
    end else begin
      // result register: load a finished answer, else empty it on a transfer
      if ((state_q == ST_DONE) && out_free) begin
        out_vld_q    <= 1'b1;
        out_inside_q <= res_q;
        out_over_q   <= dropped_q;
      end else if (out_vld_q && m_axis_tready) begin
        out_vld_q <= 1'b0;
      end

      // walk pipeline advances every cycle; a deciding edge flushes those behind it
      f_vld_q   <= iss_on_q && !walk_stop;
      f_first_q <= iss_idx_q == '0;
      f_last_q  <= iss_idx_q == cnt_q;
      d_vld_q   <= f_vld_q && !f_first_q && !walk_stop;
      d_last_q  <= f_last_q;
      m_vld_q   <= d_vld_q && !walk_stop;
      m_last_q  <= d_last_q;
      if (walk_go) begin
        iss_on_q  <= 1'b1;
        iss_idx_q <= '0;
      end else if (iss_on_q) begin
        iss_idx_q <= iss_idx_q + 1'b1;
        if ((iss_idx_q == cnt_q) || walk_stop) begin
          iss_on_q <= 1'b0;
        end
      end

      case (state_q)
        ST_IDLE: begin
          if (cmd_vld_i) begin
            case (cmd_i.op)
              pip_pkg::OP_CLEAR: begin
                cnt_q     <= '0;
                dropped_q <= 1'b0;
              end
              pip_pkg::OP_APPEND: begin
                if (not_full) begin
                  cnt_q <= cnt_q + 1'b1;
                end else begin
                  dropped_q <= 1'b1;
                end
              end
              pip_pkg::OP_QUERY: begin
                if (cnt_q == '0) begin
                  res_q   <= 1'b1;
                  state_q <= ST_DONE;
                end else begin
                  state_q <= ST_WALK;
                end
              end
              default: ;
            endcase
          end
        end
        ST_WALK: begin
          // first deciding edge ends the walk
          if (decide) begin
            res_q   <= decide_inside;
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Edge datapath: differences, then products
  always_ff @(posedge clk_i) begin
    if (pop_o && (cmd_i.op == pip_pkg::OP_QUERY)) begin
      px_q <= cmd_i.x;
      py_q <= cmd_i.y;
    end
    if (f_vld_q) begin
      prev_x_q <= rd_x;
      prev_y_q <= rd_y;
    end
    // edge from the previous vertex (b) to the fresh one (a)
    d_ux_q <= pip_pkg::sext(rd_x) - pip_pkg::sext(px_q);
    d_uy_q <= pip_pkg::sext(rd_y) - pip_pkg::sext(py_q);
    d_vx_q <= pip_pkg::sext(prev_x_q) - pip_pkg::sext(px_q);
    d_vy_q <= pip_pkg::sext(prev_y_q) - pip_pkg::sext(py_q);
    d_ex_q <= pip_pkg::sext(rd_x) - pip_pkg::sext(prev_x_q);
    d_ey_q <= pip_pkg::sext(rd_y) - pip_pkg::sext(prev_y_q);
    d_wx_q <= pip_pkg::sext(px_q) - pip_pkg::sext(prev_x_q);
    d_wy_q <= pip_pkg::sext(py_q) - pip_pkg::sext(prev_y_q);

    m_p0_q <= d_ux_q * d_vy_q;
    m_p1_q <= d_uy_q * d_vx_q;
    m_p2_q <= d_ux_q * d_vx_q;
    m_p3_q <= d_uy_q * d_vy_q;
    m_p4_q <= d_ex_q * d_wy_q;
    m_p5_q <= d_ey_q * d_wx_q;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'b0, out_over_q, out_inside_q};

  assign stat_o.cnt        = cnt_q;
  assign stat_o.dropped    = dropped_q;
  assign stat_o.res_load   = (state_q == ST_DONE) && out_free;
  assign stat_o.res_inside = res_q;

endmodule

`default_nettype wire

// ===== verif/tb_point_in_convex_polygon.sv =====
// Self-checking stream testbench for the point-in-convex-polygon block.
`timescale 1ns / 1ps

module tb_point_in_convex_polygon;

  localparam int     ACT_W        = pip_pkg::ACTION_W;
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam longint COORD_MIN    = -64'sd1073741824;
  localparam longint COORD_MAX    = 64'sd1073741823;
  localparam longint HALF_SPAN    = 64'sd536870911;
  localparam int     RANDOM_ITEMS = 540;

  // Expected answer of one query
  typedef struct packed {
    logic in_poly;
    logic dropped;
  } answer_t;

  // Golden polygon store and queue of answers still to come
  class polygon_scoreboard;
    pip_pkg::coord_t vtx_x [pip_pkg::MAX_VERTICES];
    pip_pkg::coord_t vtx_y [pip_pkg::MAX_VERTICES];
    int      vtx_count;
    bit      dropped;
    answer_t expected_answers [$];
    int      fails;
    int      checked;

    // Walk the edges in stored order; the first deciding edge wins
    function bit point_is_inside(longint px, longint py);
      longint ax, ay, bx, by;
      longint ux, uy, wx, wy;
      int     j;
      for (int i = 0; i < vtx_count; i++) begin
        j  = (i + 1 == vtx_count) ? 0 : i + 1;
        bx = vtx_x[i];
        by = vtx_y[i];
        ax = vtx_x[j];
        ay = vtx_y[j];
        ux = ax - px;
        uy = ay - py;
        wx = bx - px;
        wy = by - py;
        // on the edge itself
        if (ux * wy - uy * wx == 0 && ux * wx + uy * wy <= 0) return 1'b1;
        // strictly right of the edge
        if ((ax - bx) * (py - by) - (ay - by) * (px - bx) < 0) return 1'b0;
      end
      return 1'b1;
    endfunction

    // Update the golden state for one accepted input transfer
    function void note_command(logic [ACT_W-1:0] act, pip_pkg::coord_t x,
                               pip_pkg::coord_t y);
      answer_t ans;
      case (act)
        pip_pkg::OP_CLEAR: begin
          vtx_count = 0;
          dropped   = 1'b0;
        end
        pip_pkg::OP_APPEND: begin
          if (vtx_count < pip_pkg::MAX_VERTICES) begin
            vtx_x[vtx_count] = x;
            vtx_y[vtx_count] = y;
            vtx_count++;
          end else begin
            dropped = 1'b1;
          end
        end
        pip_pkg::OP_QUERY: begin
          ans.in_poly = point_is_inside(x, y);
          ans.dropped = dropped;
          expected_answers.insert(expected_answers.size(), ans);
        end
        default: ;
      endcase
    endfunction

    // Compare one result transfer with the oldest expected answer
    function void check_answer(logic in_bit, logic ovf_bit);
      answer_t exp_a;
      checked++;
      if (expected_answers.size() == 0) begin
        $error("unexpected result: inside_res=%0d overflowed=%0d", in_bit, ovf_bit);
        fails++;
        return;
      end
      exp_a = expected_answers.pop_front();
      if (in_bit !== exp_a.in_poly) begin
        $error("inside_res mismatch: expected %0d, actual %0d", exp_a.in_poly, in_bit);
        fails++;
      end
      if (ovf_bit !== exp_a.dropped) begin
        $error("overflowed mismatch: expected %0d, actual %0d", exp_a.dropped, ovf_bit);
        fails++;
      end
    endfunction

    function int pending();
      return expected_answers.size();
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata  = '0;  // x_coord[30:0], y_coord[61:31], zero pad
  logic [1:0]  s_axis_tuser  = '0;  // action[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // inside_res[0], overflowed[1], zero pad

  polygon_scoreboard scoreboard;

  int src_idle_pct = 26;
  int snk_idle_pct = 65;
  int items_sent   = 0;
  int queries_sent = 0;

  // What the stimulus believes is loaded, used to aim queries
  longint poly_x [pip_pkg::MAX_VERTICES];
  longint poly_y [pip_pkg::MAX_VERTICES];
  int     poly_n = 0;

  point_in_convex_polygon u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Result side back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      scoreboard.check_answer(m_axis_tdata[0], m_axis_tdata[1]);
  end

  function automatic longint rand_span(longint lo, longint hi);
    longint r;
    r = $signed({32'd0, $urandom()});
    return lo + r % (hi - lo + 1);
  endfunction

  // One input transfer, with an optional gap before it
  task automatic send_item(input logic [ACT_W-1:0] act, input longint x, input longint y);
    pip_pkg::coord_t cx, cy;
    if (x < COORD_MIN) x = COORD_MIN; else if (x > COORD_MAX) x = COORD_MAX;
    if (y < COORD_MIN) y = COORD_MIN; else if (y > COORD_MAX) y = COORD_MAX;
    cx = pip_pkg::coord_t'(x);
    cy = pip_pkg::coord_t'(y);
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, cy, cx};
    s_axis_tuser  <= act;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    scoreboard.note_command(act, cx, cy);
    if (act != ACT_UNUSED) items_sent++;
    if (act == pip_pkg::OP_QUERY) begin
      queries_sent++;
    end else if (act == pip_pkg::OP_CLEAR) begin
      poly_n = 0;
    end else if (act == pip_pkg::OP_APPEND && poly_n < pip_pkg::MAX_VERTICES) begin
      poly_x[poly_n] = cx;
      poly_y[poly_n] = cy;
      poly_n++;
    end
  endtask

  // Append a vertex given as an offset from a centre, turned by quarter turns
  task automatic add_vertex(input longint ox, input longint oy, input longint dx,
                            input longint dy, input int rot);
    longint rx, ry;
    case (rot)
      1: begin
        rx = -dy;
        ry = dx;
      end
      2: begin
        rx = -dx;
        ry = -dy;
      end
      3: begin
        rx = dy;
        ry = -dx;
      end
      default: begin
        rx = dx;
        ry = dy;
      end
    endcase
    send_item(pip_pkg::OP_APPEND, ox + rx, oy + ry);
  endtask

  // Clear, then load one shape: mostly convex counterclockwise, some degenerate, clockwise or empty
  task automatic load_shape();
    longint ox, oy, ext, a, b, s, sel, dx, dy;
    longint x0, y0, x1, y1, x2, y2, tmp;
    int     kind, rot, k;
    send_item(pip_pkg::OP_CLEAR, rand_span(COORD_MIN, COORD_MAX),
              rand_span(COORD_MIN, COORD_MAX));
    ox   = ($urandom_range(1) == 0) ? rand_span(-HALF_SPAN, HALF_SPAN) : rand_span(-500, 500);
    oy   = ($urandom_range(1) == 0) ? rand_span(-HALF_SPAN, HALF_SPAN) : rand_span(-500, 500);
    ext  = ($urandom_range(3) == 0) ? rand_span(1, HALF_SPAN) : rand_span(1, 1000);
    rot  = $urandom_range(3);
    kind = $urandom_range(99);
    if (kind < 20) begin
      // triangle, turned counterclockwise if needed
      x0 = rand_span(-ext, ext); y0 = rand_span(-ext, ext);
      x1 = rand_span(-ext, ext); y1 = rand_span(-ext, ext);
      x2 = rand_span(-ext, ext); y2 = rand_span(-ext, ext);
      if ((x1 - x0) * (y2 - y0) - (y1 - y0) * (x2 - x0) < 0) begin
        tmp = x1; x1 = x2; x2 = tmp;
        tmp = y1; y1 = y2; y2 = tmp;
      end
      add_vertex(ox, oy, x0, y0, rot);
      add_vertex(ox, oy, x1, y1, rot);
      add_vertex(ox, oy, x2, y2, rot);
    end else if (kind < 40 || kind >= 94 && kind < 97) begin
      // rectangle, reversed order for the clockwise variant
      x0 = -rand_span(0, ext); x1 = rand_span(1, ext);
      y0 = -rand_span(0, ext); y1 = rand_span(1, ext);
      if (kind < 40) begin
        add_vertex(ox, oy, x0, y0, rot);
        add_vertex(ox, oy, x1, y0, rot);
        add_vertex(ox, oy, x1, y1, rot);
        add_vertex(ox, oy, x0, y1, rot);
      end else begin
        add_vertex(ox, oy, x0, y1, rot);
        add_vertex(ox, oy, x1, y1, rot);
        add_vertex(ox, oy, x1, y0, rot);
        add_vertex(ox, oy, x0, y0, rot);
      end
    end else if (kind < 55) begin
      // octagon, convex while a/2 < b < a
      a = rand_span(3, (ext < 3) ? 3 : ext);
      b = rand_span(a / 2 + 1, a - 1);
      add_vertex(ox, oy, a, 0, rot);
      add_vertex(ox, oy, b, b, rot);
      add_vertex(ox, oy, 0, a, rot);
      add_vertex(ox, oy, -b, b, rot);
      add_vertex(ox, oy, -a, 0, rot);
      add_vertex(ox, oy, -b, -b, rot);
      add_vertex(ox, oy, 0, -a, rot);
      add_vertex(ox, oy, b, -b, rot);
    end else if (kind < 80) begin
      // points on a parabola, left to right
      k   = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
      tmp = ext / (k * k);
      s   = rand_span(1, (tmp < 1) ? 1 : tmp);
      for (int t = -k; t <= k; t++)
        add_vertex(ox, oy, s * t, s * t * t, rot);
    end else if (kind < 86) begin
      // single vertex
      add_vertex(ox, oy, rand_span(-ext, ext), rand_span(-ext, ext), 0);
    end else if (kind < 90) begin
      // two vertices: one segment travelled both ways
      add_vertex(ox, oy, rand_span(-ext, ext), rand_span(-ext, ext), 0);
      add_vertex(ox, oy, rand_span(-ext, ext), rand_span(-ext, ext), 0);
    end else if (kind < 94) begin
      // three collinear or three identical vertices
      sel = $urandom_range(1);
      dx  = rand_span(-ext, ext);
      dy  = rand_span(-ext, ext);
      for (int m = 0; m < 3; m++)
        add_vertex(ox, oy, m * dx * sel, m * dy * sel, 0);
    end
    // else: left empty
  endtask

  // One query, mostly aimed at the loaded shape: vertices, edges, their lines, vertex mean and surroundings
  task automatic query_shape();
    longint px, py, dx, dy, ga, gb, tmp, mx, my, lx, ly, hx, hy;
    int     i, j, pick;
    pick = $urandom_range(99);
    px   = rand_span(COORD_MIN, COORD_MAX);
    py   = rand_span(COORD_MIN, COORD_MAX);
    if (poly_n != 0 && pick >= 10) begin
      i = $urandom_range(poly_n - 1);
      j = (i + 1 == poly_n) ? 0 : i + 1;
      if (pick < 25) begin
        px = poly_x[i];
        py = poly_y[i];
      end else if (pick < 50) begin
        // lattice point on the edge's line, mostly within the edge
        dx = poly_x[j] - poly_x[i];
        dy = poly_y[j] - poly_y[i];
        ga = (dx < 0) ? -dx : dx;
        gb = (dy < 0) ? -dy : dy;
        while (gb != 0) begin
          tmp = ga % gb;
          ga  = gb;
          gb  = tmp;
        end
        px = poly_x[i];
        py = poly_y[i];
        if (ga != 0) begin
          tmp = rand_span(-1, ga + 1);
          px  = px + tmp * (dx / ga);
          py  = py + tmp * (dy / ga);
        end
      end else if (pick < 65) begin
        px = poly_x[i] + rand_span(-2, 2);
        py = poly_y[i] + rand_span(-2, 2);
      end else if (pick < 80) begin
        mx = 0;
        my = 0;
        for (int v = 0; v < poly_n; v++) begin
          mx += poly_x[v];
          my += poly_y[v];
        end
        px = mx / poly_n;
        py = my / poly_n;
      end else begin
        lx = poly_x[0]; hx = poly_x[0];
        ly = poly_y[0]; hy = poly_y[0];
        for (int v = 1; v < poly_n; v++) begin
          if (poly_x[v] < lx) lx = poly_x[v];
          if (poly_x[v] > hx) hx = poly_x[v];
          if (poly_y[v] < ly) ly = poly_y[v];
          if (poly_y[v] > hy) hy = poly_y[v];
        end
        px = rand_span(lx - (hx - lx) / 4 - 2, hx + (hx - lx) / 4 + 2);
        py = rand_span(ly - (hy - ly) / 4 - 2, hy + (hy - ly) / 4 + 2);
      end
    end
    send_item(pip_pkg::OP_QUERY, px, py);
  endtask

  // Hard stop
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  // Main sequence
  initial begin
    int base;
    int prog;
    int pick;
    scoreboard = new();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty, unused code, single vertex, segment, extreme triangle
    send_item(pip_pkg::OP_QUERY, 0, 0);
    send_item(ACT_UNUSED, COORD_MAX, COORD_MIN);
    send_item(pip_pkg::OP_APPEND, COORD_MIN, COORD_MAX);
    send_item(pip_pkg::OP_QUERY, COORD_MAX, COORD_MIN);
    send_item(pip_pkg::OP_CLEAR, COORD_MAX, COORD_MAX);
    send_item(pip_pkg::OP_APPEND, COORD_MIN, COORD_MIN);
    send_item(pip_pkg::OP_APPEND, COORD_MAX, COORD_MAX);
    send_item(pip_pkg::OP_QUERY, 0, 0);
    send_item(pip_pkg::OP_QUERY, 1, 0);
    send_item(pip_pkg::OP_QUERY, COORD_MAX, COORD_MAX);
    send_item(pip_pkg::OP_CLEAR, 0, 0);
    send_item(pip_pkg::OP_APPEND, COORD_MIN, COORD_MIN);
    send_item(pip_pkg::OP_APPEND, COORD_MAX, COORD_MIN);
    send_item(ACT_UNUSED, 0, 0);
    send_item(pip_pkg::OP_APPEND, 0, COORD_MAX);
    send_item(pip_pkg::OP_QUERY, 0, COORD_MIN);
    send_item(pip_pkg::OP_QUERY, 0, 0);
    send_item(pip_pkg::OP_QUERY, COORD_MIN, COORD_MAX);
    send_item(pip_pkg::OP_QUERY, COORD_MAX, COORD_MAX);
    send_item(pip_pkg::OP_QUERY, COORD_MAX, COORD_MIN);
    send_item(pip_pkg::OP_QUERY, COORD_MIN, COORD_MIN + 1);
    send_item(pip_pkg::OP_QUERY, 1, COORD_MAX);

    // Random: mostly shape-then-queries, some noise and broken sequences
    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      prog = items_sent - base;
      if (prog < RANDOM_ITEMS / 3) begin
        src_idle_pct = 26;
        snk_idle_pct = 65;
      end else if (prog < 2 * RANDOM_ITEMS / 3) begin
        src_idle_pct = 65;
        snk_idle_pct = 26;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      pick = $urandom_range(99);
      if (pick < 75) begin
        load_shape();
        repeat ($urandom_range(2, 8)) query_shape();
      end else if (pick < 87) begin
        repeat ($urandom_range(3, 8))
          send_item(ACT_W'($urandom_range(3)), rand_span(COORD_MIN, COORD_MAX),
                    rand_span(COORD_MIN, COORD_MAX));
      end else begin
        // stray vertices added to whatever is loaded
        repeat ($urandom_range(1, 3))
          send_item(pip_pkg::OP_APPEND, rand_span(COORD_MIN, COORD_MAX),
                    rand_span(COORD_MIN, COORD_MAX));
        repeat (2) query_shape();
      end
    end
    s_axis_tvalid <= 1'b0;

    // Drain, then allow the engine to settle
    while (scoreboard.pending() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);

    $display("Sent %0d commands (%0d queries), checked %0d answers.",
             items_sent, queries_sent, scoreboard.checked);
    $display("Shapes: empty, single vertex, segments, extremes, convex, clockwise, spare codes.");
    if (scoreboard.fails == 0 && scoreboard.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== point_in_convex_polygon.f =====
hdl/pip_pkg.sv
hdl/pip_front.sv
hdl/pip_cmd_fifo.sv
hdl/pip_engine.sv
hdl/point_in_convex_polygon.sv
verif/tb_point_in_convex_polygon.sv
